// ===== rtl/core/indexed_list_store_unit_defines.svh =====
// Assertion macros shared by the list store RTL.
`ifndef INDEXED_LIST_STORE_UNIT_DEFINES_SVH
`define INDEXED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, cleared during reset.
`define ILS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, cleared during reset.
`define ILS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ils_pkg.sv =====
package ils_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // What every cell does at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_APPEND     = 3'd2,
    CELL_DELETE     = 3'd3,
    CELL_ROTATE     = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ils_if.sv =====
interface ils_cmd_if import ils_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [CMD_W-1:0]   command;
  logic signed [VALUE_W-1:0] value;
  logic        [POS_W-1:0]   position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface ils_res_if import ils_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] element;
  logic                      last;
  logic                      empty_res;
  logic                      dropped;

  modport source (output valid, element, last, empty_res, dropped, input ready);
  modport sink   (input valid, element, last, empty_res, dropped, output ready);
endinterface

// ===== rtl/core/ils_cell.sv =====
module ils_cell import ils_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic        [CNT_W-1:0]   count,
  input  logic signed [VALUE_W-1:0] din,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic signed [VALUE_W-1:0] right_val,
  output logic signed [VALUE_W-1:0] val
);

  localparam logic [31:0] IDX_W32 = 32'(IDX);

  logic signed [VALUE_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.op)
      CELL_PUSH_FRONT: val_next = left_val;
      CELL_APPEND: begin
        if (IDX_W32 == 32'(count)) val_next = din;
      end
      CELL_DELETE: begin
        if (IDX_W32 >= 32'(ctrl.pos)) val_next = right_val;
      end
      CELL_ROTATE: val_next = right_val;
      default:     val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/core/indexed_list_store_unit.sv =====
// Ordered list store of up to CAPACITY signed 32-bit values, kept in a ring of
// identical cells (cell 0 is the front). A command transaction inserts at the
// front, appends at the back, or deletes at a position; a delete at or beyond
// the count does nothing, and an insert or append into a full list leaves the
// list as it is and sets dropped on every result of that listing. After each
// command the whole list is sent front to back, one result transaction per
// entry, last on the final one; an empty list sends a single result with
// empty_res set and a zero element. Timing: the command is applied in the
// cycle it is taken, then the ring rotates by one cell per cycle, emitting
// cell 0 while the step is below the count, until the last step;
// back-pressure on the result side only pauses the rotation. Commands are
// taken only between listings. Entries need no clearing after reset: only
// cells below the count are ever sent.
module indexed_list_store_unit import ils_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic        clk,
  input logic        rst,
  ils_cmd_if.sink    cmd,
  ils_res_if.source  res
);

  `include "indexed_list_store_unit_defines.svh"

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                refused, refused_next;

  // result holding register
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_element;
  logic                      out_last;
  logic                      out_empty;
  logic                      out_dropped;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] vals [CAPACITY];

  logic cmd_take;
  logic out_free;
  logic emit;
  logic emit_empty;
  logic advance;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || res.ready;

  // list entry k sits in cell 0 at step k
  assign emit_empty = (count == '0) && (step == '0);
  assign emit       = (CNT_W'(step) < count) || emit_empty;
  assign advance    = (state == ST_LIST) && (!emit || out_free);

  // command decode and ring control
  always_comb begin
    count_next   = count;
    refused_next = refused;
    ctrl.op      = CELL_HOLD;
    ctrl.pos     = cmd.position;
    if (cmd_take) begin
      refused_next = 1'b0;
      case (cmd.command)
        CMD_INSERT: begin
          if (count == CNT_FULL) begin
            refused_next = 1'b1;
          end else begin
            ctrl.op    = CELL_PUSH_FRONT;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_APPEND: begin
          if (count == CNT_FULL) begin
            refused_next = 1'b1;
          end else begin
            ctrl.op    = CELL_APPEND;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_DELETE: begin
          if (32'(cmd.position) < 32'(count)) begin
            ctrl.op    = CELL_DELETE;
            count_next = count - CNT_W'(1);
          end
        end
        default: ctrl.op = CELL_HOLD;
      endcase
    end else if (advance) begin
      ctrl.op = CELL_ROTATE;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          state_next = ST_LIST;
          step_next  = '0;
        end
      end
      ST_LIST: begin
        if (advance) begin
          if (step == STEP_LAST) begin
            state_next = ST_IDLE;
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      refused   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      step    <= step_next;
      refused <= refused_next;
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_element <= emit_empty ? '0 : vals[0];
      out_last    <= emit_empty || (CNT_W'(step) == count - CNT_W'(1));
      out_empty   <= emit_empty;
      out_dropped <= refused;
    end
  end

  assign res.valid     = out_valid;
  assign res.element   = out_element;
  assign res.last      = out_last;
  assign res.empty_res = out_empty;
  assign res.dropped   = out_dropped;

  // ring of cells: left neighbour feeds a front insert, right neighbour
  // feeds delete and rotation, the back cell wraps round to cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;

    if (i == 0) begin : g_front
      assign left_val = cmd.value;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_val = vals[0];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    ils_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .din       (cmd.value),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[i])
    );
  end

  // checks
  `ILS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL,
    "entry count beyond capacity")
  `ILS_ASSERT_NOW(a_empty_is_last, clk, rst, out_valid && out_empty, out_last,
    "empty result not marked last")
  `ILS_ASSERT_NEXT(a_take_starts_list, clk, rst, cmd_take,
    (state == ST_LIST) && (step == '0), "listing did not start after command")

endmodule
